[hdl/mac_learning_forward_table_core_defines.svh]
`ifndef MAC_LEARNING_FORWARD_TABLE_CORE_DEFINES_SVH
`define MAC_LEARNING_FORWARD_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define MLFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked while out of reset.
`define MLFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mlft_pkg.sv]
`timescale 1ns / 1ps
package mlft_pkg;

  localparam int MAC_W    = 48;
  localparam int PORT_W   = 6;
  localparam int AGE_W    = 16;
  localparam int CNT_W    = 14;
  localparam int HASH_W   = 32;
  localparam int OPEN_N   = 64;  // one open bit per encodable port
  localparam logic [CNT_W-1:0] EV_MAX = '1;

  typedef enum logic [1:0] {
    CMD_FRAME = 2'd0,
    CMD_AGE   = 2'd1,
    CMD_PORT  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [MAC_W-1:0]  dst_mac;
    logic [MAC_W-1:0]  src_mac;
    logic [PORT_W-1:0] port;
    logic              open_val;
    logic [HASH_W-1:0] dst_hash;
    logic [HASH_W-1:0] src_hash;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic [AGE_W-1:0]  age;
    logic [PORT_W-1:0] port;
    logic [MAC_W-1:0]  mac;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
    logic [HASH_W-1:0] c;
  } mix_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MIX,
    F_PUSH
  } fstate_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_DST,
    B_SRC,
    B_AGE
  } bstate_t;

  // Back-end status seen by the front end: queue full and table clearing.
  typedef struct packed {
    logic full;
    logic clearing;
  } back_stat_t;

  function automatic logic [HASH_W-1:0] rotl(input logic [HASH_W-1:0] x, input int k);
    rotl = (x << k) | (x >> (HASH_W - k));
  endfunction

  // One step of the final mix; step codes past the last leave the state as is.
  function automatic mix_t mix_step(input mix_t s, input logic [2:0] j);
    mix_t r;
    r = s;
    unique case (j)
      3'd0: r.c = (s.c ^ s.b) - rotl(s.b, 14);
      3'd1: r.a = (s.a ^ s.c) - rotl(s.c, 11);
      3'd2: r.b = (s.b ^ s.a) - rotl(s.a, 25);
      3'd3: r.c = (s.c ^ s.b) - rotl(s.b, 16);
      3'd4: r.a = (s.a ^ s.c) - rotl(s.c, 4);
      3'd5: r.b = (s.b ^ s.a) - rotl(s.a, 14);
      3'd6: r.c = (s.c ^ s.b) - rotl(s.b, 24);
      default: r = s;
    endcase
    return r;
  endfunction

  function automatic mix_t mix_init(input logic [MAC_W-1:0] m);
    mix_t r;
    r.a = {16'd0, m[15:0]};
    r.b = {16'd0, m[31:16]};
    r.c = {16'd0, m[47:32]};
    return r;
  endfunction

endpackage

[hdl/mlft_ram.sv]
`timescale 1ns / 1ps
module mlft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/mlft_fifo.sv]
`timescale 1ns / 1ps
module mlft_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mlft_pkg::item_t din,
  input  logic           pop,
  output mlft_pkg::item_t dout,
  output logic           valid,
  output logic           full
);

  // two-entry queue
  mlft_pkg::item_t slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop  ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= din;
    end
  end

  assign dout  = slot_r[rp_r];
  assign valid = (cnt_r != 2'd0);
  assign full  = (cnt_r == 2'd2);

endmodule

[hdl/mlft_front.sv]
`timescale 1ns / 1ps
module mlft_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [1:0]                        in_command,
  input  logic [mlft_pkg::MAC_W-1:0]        in_dst_mac,
  input  logic [mlft_pkg::MAC_W-1:0]        in_src_mac,
  input  logic [mlft_pkg::PORT_W-1:0]       in_port,
  input  logic                              in_port_open_value,
  input  mlft_pkg::back_stat_t              stat,
  output logic                              busy,
  output logic                              push,
  output mlft_pkg::item_t                   push_item
);

  mlft_pkg::fstate_t state_r, state_nxt;
  mlft_pkg::item_t   item_r;
  mlft_pkg::mix_t    hd_r, hs_r;
  logic [2:0]        step_r;
  logic              accept;

  assign accept = start && !busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mlft_pkg::F_IDLE: begin
        if (accept) begin
          // only frames need hashing
          state_nxt = (mlft_pkg::cmd_t'(in_command) == mlft_pkg::CMD_FRAME) ?
                      mlft_pkg::F_MIX : mlft_pkg::F_PUSH;
        end
      end
      mlft_pkg::F_MIX: begin
        if (step_r == 3'd6) begin
          state_nxt = mlft_pkg::F_PUSH;
        end
      end
      mlft_pkg::F_PUSH: begin
        if (!stat.full) begin
          state_nxt = mlft_pkg::F_IDLE;
        end
      end
      default: state_nxt = mlft_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = (state_r != mlft_pkg::F_IDLE) || stat.clearing;
    push      = (state_r == mlft_pkg::F_PUSH) && !stat.full;
    push_item = item_r;
    push_item.dst_hash = hd_r.c;
    push_item.src_hash = hs_r.c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlft_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (accept) begin
      item_r.cmd      <= mlft_pkg::cmd_t'(in_command);
      item_r.dst_mac  <= in_dst_mac;
      item_r.src_mac  <= in_src_mac;
      item_r.port     <= in_port;
      item_r.open_val <= in_port_open_value;
      item_r.dst_hash <= '0;
      item_r.src_hash <= '0;
      hd_r            <= mlft_pkg::mix_init(in_dst_mac);
      hs_r            <= mlft_pkg::mix_init(in_src_mac);
      step_r          <= 3'd0;
    end else if (state_r == mlft_pkg::F_MIX) begin
      // two mix steps per cycle
      hd_r   <= mlft_pkg::mix_step(mlft_pkg::mix_step(hd_r, step_r), step_r + 3'd1);
      hs_r   <= mlft_pkg::mix_step(mlft_pkg::mix_step(hs_r, step_r), step_r + 3'd1);
      step_r <= step_r + 3'd2;
    end
  end

endmodule

[hdl/mlft_back.sv]
`timescale 1ns / 1ps
module mlft_back #(
  parameter int TABLE_ENTRIES = 8192,
  parameter int PORTS         = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [mlft_pkg::AGE_W-1:0]   max_age,
  input  logic                         q_valid,
  input  mlft_pkg::item_t              q_item,
  output logic                         q_pop,
  output logic                         clearing,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [mlft_pkg::PORT_W-1:0] out_port,
  output logic                         out_flood,
  output logic                         out_learn_failed,
  output logic [mlft_pkg::CNT_W-1:0]  out_evicted_count
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] N_C = CW'(TABLE_ENTRIES);

  mlft_pkg::bstate_t state_r, state_nxt;
  mlft_pkg::item_t   item_r, item_nxt;
  logic [IW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     step_r, step_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              rv_r, rv_nxt;
  logic [IW-1:0]     wa_r, wa_nxt;
  logic              hit_r, hit_nxt;
  logic [mlft_pkg::PORT_W-1:0] hport_r, hport_nxt;
  logic [mlft_pkg::CNT_W-1:0]  ev_r, ev_nxt;
  logic [mlft_pkg::OPEN_N-1:0] open_r, open_nxt;

  logic              ov_r, ov_nxt;
  logic              ohit_r, ohit_nxt;
  logic [mlft_pkg::PORT_W-1:0] oport_r, oport_nxt;
  logic              oflood_r, oflood_nxt;
  logic              ofail_r, ofail_nxt;
  logic [mlft_pkg::CNT_W-1:0]  oev_r, oev_nxt;

  logic              ram_we;
  logic [IW-1:0]     ram_wa, ram_ra;
  mlft_pkg::entry_t  ram_wd, ram_rd;

  logic              match_d, match_s, last, issue, age_done;
  logic [IW-1:0]     adv, dst_pos, src_pos;
  logic [mlft_pkg::AGE_W-1:0] age_inc;
  logic              evict;

  mlft_ram #(
    .WIDTH (mlft_pkg::ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (ram_ra),
    .rdata (ram_rd)
  );

  assign match_d  = (ram_rd.mac == item_r.dst_mac) || !ram_rd.valid;
  assign match_s  = (ram_rd.mac == item_r.src_mac) || !ram_rd.valid;
  assign last     = (step_r == N_C);
  assign adv      = pos_r + step_r[IW-1:0];
  assign dst_pos  = q_item.dst_hash[IW-1:0];
  assign src_pos  = item_r.src_hash[IW-1:0];
  assign issue    = (cnt_r < N_C);
  assign age_done = !issue && !rv_r;
  assign age_inc  = ram_rd.age + 16'd1;
  assign evict    = ram_rd.valid && ((age_inc >= max_age) || !open_r[ram_rd.port]);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mlft_pkg::B_CLEAR: begin
        if (cnt_r == N_C - CW'(1)) begin
          state_nxt = mlft_pkg::B_IDLE;
        end
      end
      mlft_pkg::B_IDLE: begin
        if (q_valid) begin
          priority if (q_item.cmd == mlft_pkg::CMD_FRAME) begin
            state_nxt = mlft_pkg::B_DST;
          end else if (q_item.cmd == mlft_pkg::CMD_AGE) begin
            state_nxt = mlft_pkg::B_AGE;
          end else begin
            state_nxt = mlft_pkg::B_IDLE;
          end
        end
      end
      mlft_pkg::B_DST: begin
        if (match_d || last) begin
          state_nxt = mlft_pkg::B_SRC;
        end
      end
      mlft_pkg::B_SRC: begin
        if (match_s || last) begin
          state_nxt = mlft_pkg::B_IDLE;
        end
      end
      mlft_pkg::B_AGE: begin
        if (age_done) begin
          state_nxt = mlft_pkg::B_IDLE;
        end
      end
      default: state_nxt = mlft_pkg::B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ram_we     = 1'b0;
    ram_wa     = pos_r;
    ram_wd     = '0;
    ram_ra     = pos_r;
    q_pop      = 1'b0;
    item_nxt   = item_r;
    pos_nxt    = pos_r;
    step_nxt   = step_r;
    cnt_nxt    = cnt_r;
    rv_nxt     = 1'b0;
    wa_nxt     = wa_r;
    hit_nxt    = hit_r;
    hport_nxt  = hport_r;
    ev_nxt     = ev_r;
    open_nxt   = open_r;
    ov_nxt     = 1'b0;
    ohit_nxt   = ohit_r;
    oport_nxt  = oport_r;
    oflood_nxt = oflood_r;
    ofail_nxt  = ofail_r;
    oev_nxt    = oev_r;

    unique case (state_r)
      mlft_pkg::B_CLEAR: begin
        ram_we  = 1'b1;
        ram_wa  = cnt_r[IW-1:0];
        cnt_nxt = cnt_r + CW'(1);
      end
      mlft_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          unique case (q_item.cmd)
            mlft_pkg::CMD_FRAME: begin
              ram_ra   = dst_pos;
              pos_nxt  = dst_pos;
              step_nxt = CW'(1);
            end
            mlft_pkg::CMD_AGE: begin
              cnt_nxt = '0;
              ev_nxt  = '0;
            end
            mlft_pkg::CMD_PORT, mlft_pkg::CMD_NONE: begin
              if ((q_item.cmd == mlft_pkg::CMD_PORT) && (int'(q_item.port) < PORTS)) begin
                open_nxt[q_item.port] = q_item.open_val;
              end
              ov_nxt     = 1'b1;
              ohit_nxt   = 1'b0;
              oport_nxt  = '0;
              oflood_nxt = 1'b0;
              ofail_nxt  = 1'b0;
              oev_nxt    = '0;
            end
            default: ;
          endcase
        end
      end
      mlft_pkg::B_DST: begin
        if (match_d || last) begin
          hit_nxt   = match_d && ram_rd.valid;
          hport_nxt = (match_d && ram_rd.valid) ? ram_rd.port : '0;
          ram_ra    = src_pos;
          pos_nxt   = src_pos;
          step_nxt  = CW'(1);
        end else begin
          ram_ra   = adv;
          pos_nxt  = adv;
          step_nxt = step_r + CW'(1);
        end
      end
      mlft_pkg::B_SRC: begin
        if (match_s || last) begin
          if (match_s) begin
            ram_we       = 1'b1;
            ram_wa       = pos_r;
            ram_wd.valid = 1'b1;
            ram_wd.age   = '0;
            ram_wd.port  = item_r.port;
            ram_wd.mac   = item_r.src_mac;
          end
          ov_nxt     = 1'b1;
          ohit_nxt   = hit_r;
          oport_nxt  = hport_r;
          oflood_nxt = !hit_r;
          ofail_nxt  = !match_s;
          oev_nxt    = '0;
        end else begin
          ram_ra   = adv;
          pos_nxt  = adv;
          step_nxt = step_r + CW'(1);
        end
      end
      mlft_pkg::B_AGE: begin
        // read entry i while writing back entry i-1
        ram_ra = cnt_r[IW-1:0];
        if (issue) begin
          cnt_nxt = cnt_r + CW'(1);
          rv_nxt  = 1'b1;
          wa_nxt  = cnt_r[IW-1:0];
        end
        if (rv_r) begin
          ram_we     = 1'b1;
          ram_wa     = wa_r;
          ram_wd     = ram_rd;
          ram_wd.age = age_inc;
          if (evict) begin
            ram_wd.valid = 1'b0;
            ram_wd.port  = '0;
            ram_wd.mac   = '0;
            if (ev_r != mlft_pkg::EV_MAX) begin
              ev_nxt = ev_r + mlft_pkg::CNT_W'(1);
            end
          end
        end
        if (age_done) begin
          ov_nxt     = 1'b1;
          ohit_nxt   = 1'b0;
          oport_nxt  = '0;
          oflood_nxt = 1'b0;
          ofail_nxt  = 1'b0;
          oev_nxt    = ev_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlft_pkg::B_CLEAR;
      cnt_r   <= '0;
      rv_r    <= 1'b0;
      open_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rv_r    <= rv_nxt;
      open_r  <= open_nxt;
      ov_r    <= ov_nxt;
    end
    item_r   <= item_nxt;
    pos_r    <= pos_nxt;
    step_r   <= step_nxt;
    wa_r     <= wa_nxt;
    hit_r    <= hit_nxt;
    hport_r  <= hport_nxt;
    ev_r     <= ev_nxt;
    ohit_r   <= ohit_nxt;
    oport_r  <= oport_nxt;
    oflood_r <= oflood_nxt;
    ofail_r  <= ofail_nxt;
    oev_r    <= oev_nxt;
  end

  assign clearing          = (state_r == mlft_pkg::B_CLEAR);
  assign out_valid         = ov_r;
  assign out_hit           = ohit_r;
  assign out_port          = oport_r;
  assign out_flood         = oflood_r;
  assign out_learn_failed  = ofail_r;
  assign out_evicted_count = oev_r;

endmodule

[hdl/mac_learning_forward_table_core.sv]
`timescale 1ns / 1ps
// Layer-2 address table: a frame command (0) looks up dst_mac and learns src_mac,
// an aging command (1) sweeps the whole table, a port command (2) opens or closes
// a port. Issue a command with start while busy is low; exactly one result beat
// per command comes back on out_valid, in command order, and must be taken in
// that cycle since there is no backpressure. After reset the table is cleared
// one entry per clock, and busy stays high until the table is clear. A frame is
// hashed in the front end, then the back end probes for the destination and then
// the source, each stopping at the first slot holding the address or empty;
// the front end hashes the next frame while the back end probes. An aging sweep
// reads entry i while writing back entry i-1, as the table memory has one read
// and one write port; a port command is handled as it leaves the queue. Write
// max_age (cfg_we/cfg_wdata) only while no command is pending.
module mac_learning_forward_table_core #(
  parameter int TABLE_ENTRIES = 8192,  // power of two
  parameter int PORTS         = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_command,
  input  logic [mlft_pkg::MAC_W-1:0]  in_dst_mac,
  input  logic [mlft_pkg::MAC_W-1:0]  in_src_mac,
  input  logic [mlft_pkg::PORT_W-1:0] in_port,
  input  logic                         in_port_open_value,
  input  logic                         cfg_we,
  input  logic [mlft_pkg::AGE_W-1:0]  cfg_wdata,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [mlft_pkg::PORT_W-1:0] out_port,
  output logic                         out_flood,
  output logic                         out_learn_failed,
  output logic [mlft_pkg::CNT_W-1:0]  out_evicted_count
);

  logic [mlft_pkg::AGE_W-1:0] max_age_r;

  mlft_pkg::back_stat_t stat;
  mlft_pkg::item_t      push_item, q_item;
  logic                 push, q_valid, q_full, q_pop, clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_age_r <= 16'd2;
    end else if (cfg_we) begin
      max_age_r <= cfg_wdata;
    end
  end

  assign stat.full     = q_full;
  assign stat.clearing = clearing;

  // front end: accept, classify, hash
  mlft_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .in_command         (in_command),
    .in_dst_mac         (in_dst_mac),
    .in_src_mac         (in_src_mac),
    .in_port            (in_port),
    .in_port_open_value (in_port_open_value),
    .stat               (stat),
    .busy               (busy),
    .push               (push),
    .push_item          (push_item)
  );

  // command queue between the two halves
  mlft_fifo u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (push_item),
    .pop   (q_pop),
    .dout  (q_item),
    .valid (q_valid),
    .full  (q_full)
  );

  // back end: probe, learn, age, port state
  mlft_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PORTS         (PORTS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .max_age           (max_age_r),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_port          (out_port),
    .out_flood         (out_flood),
    .out_learn_failed  (out_learn_failed),
    .out_evicted_count (out_evicted_count)
  );

endmodule

[hdl/mlft_checker.sv]
`timescale 1ns / 1ps
`include "mac_learning_forward_table_core_defines.svh"
module mlft_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic                         out_hit,
  input logic [mlft_pkg::PORT_W-1:0] out_port,
  input logic                         out_flood,
  input logic                         out_learn_failed,
  input logic [mlft_pkg::CNT_W-1:0]  out_evicted_count
);

  `MLFT_ASSERT_NOW(a_hit_xor_flood, out_valid, !(out_hit && out_flood), "hit and flood together")
  `MLFT_ASSERT_NOW(a_port_on_hit, out_valid && !out_hit, out_port == '0, "port without hit")
  `MLFT_ASSERT_NOW(a_evict_only_sweep, out_valid && (out_evicted_count != '0),
                   !out_hit && !out_flood && !out_learn_failed, "eviction on frame result")
  `MLFT_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "accepted beat left busy low")

endmodule

bind mac_learning_forward_table_core mlft_checker u_mlft_checker (.*);

[tb/mac_learning_forward_table_core_test.sv]
`timescale 1ns / 1ps
module mac_learning_forward_table_core_test;
  import mlft_pkg::*;

  localparam int SLOTS = 8192;
  localparam int NPORT = 64;

  // One result beat as the block reports it.
  typedef struct packed {
    logic              hit;
    logic [PORT_W-1:0] port;
    logic              flood;
    logic              learn_failed;
    logic [CNT_W-1:0]  evicted;
  } fwd_result_t;

  // One directed row: either a command beat or a max_age write.
  typedef struct {
    bit                is_cfg;
    logic [AGE_W-1:0]  cfg_val;
    cmd_t              cmd;
    logic [MAC_W-1:0]  dst;
    logic [MAC_W-1:0]  src;
    logic [PORT_W-1:0] port;
    logic              open_val;
    bit                has_lit;   // expected beat typed in below
    fwd_result_t       lit;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_command = CMD_NONE;
  logic [MAC_W-1:0] in_dst_mac = '0;
  logic [MAC_W-1:0] in_src_mac = '0;
  logic [PORT_W-1:0] in_port = '0;
  logic in_port_open_value = 1'b0;
  logic cfg_we = 1'b0;
  logic [AGE_W-1:0] cfg_wdata = '0;
  logic out_valid;
  logic out_hit;
  logic [PORT_W-1:0] out_port;
  logic out_flood;
  logic out_learn_failed;
  logic [CNT_W-1:0] out_evicted_count;

  always #5 clk = ~clk;

  mac_learning_forward_table_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_dst_mac(in_dst_mac), .in_src_mac(in_src_mac),
    .in_port(in_port), .in_port_open_value(in_port_open_value),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_hit(out_hit), .out_port(out_port),
    .out_flood(out_flood), .out_learn_failed(out_learn_failed),
    .out_evicted_count(out_evicted_count)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the address table, kept in step with every accepted beat.
  // ---------------------------------------------------------------------------
  logic [MAC_W-1:0]  sh_mac   [SLOTS];
  logic [PORT_W-1:0] sh_port  [SLOTS];
  logic              sh_valid [SLOTS];
  logic [AGE_W-1:0]  sh_age   [SLOTS];
  logic              sh_open  [NPORT];
  logic [AGE_W-1:0]  sh_max_age;

  fwd_result_t pending_results[$];
  int errors = 0;
  int sender_idle_pct = 0;

  function automatic logic [31:0] rot(input logic [31:0] x, input int k);
    return (x << k) | (x >> (32 - k));
  endfunction

  // lookup3-style final mix over the three 16-bit chunks of the address
  function automatic logic [31:0] addr_hash(input logic [MAC_W-1:0] m);
    logic [31:0] a, b, c;
    a = {16'd0, m[15:0]};
    b = {16'd0, m[31:16]};
    c = {16'd0, m[47:32]};
    c = (c ^ b) - rot(b, 14);
    a = (a ^ c) - rot(c, 11);
    b = (b ^ a) - rot(a, 25);
    c = (c ^ b) - rot(b, 16);
    a = (a ^ c) - rot(c, 4);
    b = (b ^ a) - rot(a, 14);
    c = (c ^ b) - rot(b, 24);
    return c;
  endfunction

  // Triangular probe: first slot holding the address or empty (no tombstones).
  function automatic bit find_slot(input logic [MAC_W-1:0] m, output int slot);
    int pos;
    pos = addr_hash(m) % SLOTS;
    slot = 0;
    for (int step = 1; step <= SLOTS; step++) begin
      if (sh_mac[pos] == m || !sh_valid[pos]) begin
        slot = pos;
        return 1'b1;
      end
      pos = (pos + step) % SLOTS;
    end
    return 1'b0;
  endfunction

  function automatic fwd_result_t forward_and_learn(input cmd_t cmd,
      input logic [MAC_W-1:0] dst, input logic [MAC_W-1:0] src,
      input logic [PORT_W-1:0] port, input logic open_val);
    fwd_result_t r;
    int slot;
    int age_next;
    r = '0;
    case (cmd)
      CMD_FRAME: begin
        if (find_slot(dst, slot) && sh_valid[slot]) begin
          r.hit = 1'b1;
          r.port = sh_port[slot];
        end else begin
          r.flood = 1'b1;
        end
        if (find_slot(src, slot)) begin
          sh_mac[slot] = src;
          sh_port[slot] = port;
          sh_age[slot] = '0;
          sh_valid[slot] = 1'b1;
        end else begin
          r.learn_failed = 1'b1;
        end
      end
      CMD_AGE: begin
        for (int i = 0; i < SLOTS; i++) begin
          sh_age[i] = sh_age[i] + 1'b1;
          age_next = sh_age[i];
          if (sh_valid[i] && (age_next >= sh_max_age || !sh_open[sh_port[i]])) begin
            sh_valid[i] = 1'b0;
            sh_mac[i] = '0;
            sh_port[i] = '0;
            if (r.evicted != EV_MAX) r.evicted = r.evicted + 1'b1;
          end
        end
      end
      CMD_PORT: sh_open[port] = open_val;
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: the receiver never stalls, so every out_valid is a beat.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: MISMATCH %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    fwd_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", out_evicted_count, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_hit !== want.hit) report_mismatch("hit", out_hit, want.hit);
        if (out_port !== want.port) report_mismatch("port", out_port, want.port);
        if (out_flood !== want.flood) report_mismatch("flood", out_flood, want.flood);
        if (out_learn_failed !== want.learn_failed)
          report_mismatch("learn_failed", out_learn_failed, want.learn_failed);
        if (out_evicted_count !== want.evicted)
          report_mismatch("evicted_count", out_evicted_count, want.evicted);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // Drive one command beat, hold start until accepted, then maybe idle.
  task automatic send_beat(input cmd_t cmd, input logic [MAC_W-1:0] dst,
      input logic [MAC_W-1:0] src, input logic [PORT_W-1:0] port,
      input logic open_val, input bit has_lit, input fwd_result_t lit);
    fwd_result_t r;
    in_command <= cmd;
    in_dst_mac <= dst;
    in_src_mac <= src;
    in_port <= port;
    in_port_open_value <= open_val;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    r = forward_and_learn(cmd, dst, src, port, open_val);
    pending_results.push_back(has_lit ? lit : r);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Let the block drain fully; every command returns exactly one beat.
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_max_age(input logic [AGE_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_max_age = v;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  row_t directed[$];
  logic [MAC_W-1:0] addr_pool[$];   // reused addresses so lookups hit
  logic [MAC_W-1:0] collide[$];     // addresses sharing one home slot

  function automatic row_t mk_row(input cmd_t cmd, input logic [MAC_W-1:0] dst,
      input logic [MAC_W-1:0] src, input logic [PORT_W-1:0] port,
      input logic open_val, input bit has_lit, input fwd_result_t lit);
    row_t r;
    r.is_cfg = 0;
    r.cfg_val = '0;
    r.cmd = cmd;
    r.dst = dst;
    r.src = src;
    r.port = port;
    r.open_val = open_val;
    r.has_lit = has_lit;
    r.lit = lit;
    return r;
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[MAC_W-1:0];
  endfunction

  function automatic logic [MAC_W-1:0] pick_mac();
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) return rand_mac();
    if (sel < 35) return collide[$urandom_range(collide.size() - 1)];
    return addr_pool[$urandom_range(addr_pool.size() - 1)];
  endfunction

  initial begin
    localparam logic [MAC_W-1:0] ONES = '1;
    localparam logic [MAC_W-1:0] MAC_A = 48'h0000_5E00_0153;
    localparam logic [MAC_W-1:0] MAC_B = 48'hA5A5_5A5A_0F0F;
    // expected beats for the directed rows
    fwd_result_t flood_only, quiet, hit63, hit0, hit5, ev1, ev2, none;
    logic [MAC_W-1:0] m;
    int home;
    row_t cfg_row;
    int sel;
    cmd_t cmd;

    for (int i = 0; i < SLOTS; i++) begin
      sh_mac[i] = '0; sh_port[i] = '0; sh_valid[i] = 1'b0; sh_age[i] = '0;
    end
    for (int p = 0; p < NPORT; p++) sh_open[p] = 1'b0;
    sh_max_age = 16'd2;

    // Find a handful of addresses that hash to the same home slot so that
    // probe chains, chain holes after eviction and re-learning get exercised.
    m = rand_mac();
    collide.push_back(m);
    home = addr_hash(m) % SLOTS;
    while (collide.size() < 5) begin
      m = rand_mac();
      if (addr_hash(m) % SLOTS == home) collide.push_back(m);
    end
    for (int i = 0; i < 40; i++) addr_pool.push_back(rand_mac());

    none = '0;
    flood_only = '0; flood_only.flood = 1'b1;
    quiet = '0;
    hit63 = '0; hit63.hit = 1'b1; hit63.port = 6'd63;
    hit0 = '0; hit0.hit = 1'b1;
    hit5 = '0; hit5.hit = 1'b1; hit5.port = 6'd5;
    ev1 = '0; ev1.evicted = 14'd1;
    ev2 = '0; ev2.evicted = 14'd2;

    // empty table: first frames flood, then all-zero and all-ones addresses hit
    directed.push_back(mk_row(CMD_FRAME, '0, '0, 6'd0, 1'b0, 1, flood_only));
    directed.push_back(mk_row(CMD_FRAME, ONES, ONES, 6'd63, 1'b1, 1, flood_only));
    directed.push_back(mk_row(CMD_FRAME, ONES, MAC_A, 6'd5, 1'b0, 1, hit63));
    directed.push_back(mk_row(CMD_FRAME, '0, '0, 6'd0, 1'b0, 1, hit0));
    // unused opcode does nothing
    directed.push_back(mk_row(CMD_NONE, ONES, ONES, 6'd63, 1'b1, 1, quiet));
    directed.push_back(mk_row(CMD_PORT, '0, '0, 6'd5, 1'b1, 1, quiet));
    directed.push_back(mk_row(CMD_PORT, '0, '0, 6'd63, 1'b1, 1, quiet));
    // port 0 still closed: its entry goes on the first sweep
    directed.push_back(mk_row(CMD_AGE, '0, '0, 6'd0, 1'b0, 1, ev1));
    directed.push_back(mk_row(CMD_FRAME, MAC_A, MAC_B, 6'd63, 1'b0, 1, hit5));
    // max_age 2 reached by the two older entries
    directed.push_back(mk_row(CMD_AGE, '0, '0, 6'd0, 1'b0, 1, ev2));
    directed.push_back(mk_row(CMD_PORT, '0, '0, 6'd63, 1'b0, 1, quiet));
    // port 63 closed; its entry also reaches max_age on this sweep
    directed.push_back(mk_row(CMD_AGE, '0, '0, 6'd0, 1'b0, 1, ev1));
    // collision chain, then a hole in it, checked by the shadow table
    for (int i = 0; i < 4; i++)
      directed.push_back(mk_row(CMD_FRAME, collide[i], collide[i], 6'(i + 1), 1'b1, 0, none));
    directed.push_back(mk_row(CMD_PORT, '0, '0, 6'd2, 1'b1, 0, none));
    directed.push_back(mk_row(CMD_AGE, '0, '0, 6'd0, 1'b0, 0, none));
    directed.push_back(mk_row(CMD_FRAME, collide[1], collide[3], 6'd9, 1'b0, 0, none));
    // zero max_age evicts everything on the next sweep
    cfg_row = mk_row(CMD_NONE, '0, '0, '0, 1'b0, 0, none);
    cfg_row.is_cfg = 1;
    cfg_row.cfg_val = 16'd0;
    directed.push_back(cfg_row);
    directed.push_back(mk_row(CMD_FRAME, collide[2], MAC_A, 6'd5, 1'b1, 0, none));
    directed.push_back(mk_row(CMD_AGE, '0, '0, 6'd0, 1'b0, 0, none));
    directed.push_back(mk_row(CMD_FRAME, MAC_A, collide[4], 6'd63, 1'b0, 0, none));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        write_max_age(directed[i].cfg_val);
      end else begin
        send_beat(directed[i].cmd, directed[i].dst, directed[i].src, directed[i].port,
                  directed[i].open_val, directed[i].has_lit, directed[i].lit);
      end
    end

    // Random phases: sender idles 38%, then 53%, then never. Each phase runs
    // with its own max_age, including the top of the range.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: write_max_age(16'd3);
        1: write_max_age(16'hFFFF);
        default: write_max_age(16'd1);
      endcase
      sender_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 53 : 0;
      // open most ports so learned entries are not evicted for a closed port
      for (int p = 0; p < NPORT; p++)
        if ($urandom_range(9) < 8) send_beat(CMD_PORT, '0, '0, 6'(p), 1'b1, 0, none);
      for (int n = 0; n < 520; n++) begin
        // once per phase, hold off until the block has returned everything
        if (n == 260) drain();
        sel = $urandom_range(999);
        if (sel < 820) cmd = CMD_FRAME;
        else if (sel < 940) cmd = CMD_PORT;
        else if (sel < 960) cmd = CMD_AGE;
        else cmd = CMD_NONE;
        send_beat(cmd, pick_mac(), pick_mac(), 6'($urandom_range(63)),
                  (cmd == CMD_PORT) ? ($urandom_range(9) < 8) : 1'($urandom()), 0, none);
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop: well beyond the reset clear, all sweeps and idle gaps.
  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
